// ----- src/sedh_pkg.sv -----
// Shared types and constants for the serpentine error-diffusion halftoner.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package sedh_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int FRAC_BITS = 6;

  localparam int PIX_BITS = 8;
  localparam int WIDTH_CFG_BITS = 11;
  localparam int THR_BITS = 8;

  // Ink sums saturate to [-(512 << FRAC_BITS), (512 << FRAC_BITS) - 1].
  localparam int ERR_BITS = 10 + FRAC_BITS;
  localparam int SUM_BITS = ERR_BITS + 2;
  localparam int CHANNELS = 3;

  localparam logic signed [SUM_BITS-1:0] VMAX = SUM_BITS'((1 << (ERR_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] VMIN = SUM_BITS'(-(1 << (ERR_BITS - 1)));
  localparam logic signed [ERR_BITS-1:0] FULL_INK = ERR_BITS'(255 << FRAC_BITS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = WIDTH_CFG_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = CFG_INDEX_BITS'(1);

  localparam int IMAGE_WIDTH_RESET = 256;
  localparam int THRESHOLD_RESET = 128;

  typedef logic [CHANNELS-1:0][ERR_BITS-1:0] err_row_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic [COL_BITS-1:0] x;
    logic [COL_BITS-1:0] behind;
    logic last;
    logic has_behind;
    logic first_row;
    logic clear;
  } sedh_desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } sedh_queue_status_t;

endpackage

`default_nettype wire

// ----- src/serpentine_error_diffusion_halftone.sv -----
// Top level of the serpentine error-diffusion halftoner: configuration
// registers and the front end, queue and back end. Depends on sedh_pkg.
//
// Pixels enter on the in_ channel in serpentine order (even rows left to
// right, odd rows right to left); frame_start marks the first pixel of an
// image. An item is taken at a rising edge with in_valid high and in_stall
// low. Each pixel gives one item on the out_ channel with three binary
// colors, taken at an edge with out_valid high and out_stall low.
// A pixel passes the queue, the s1 stage and the output register.
// Throughput is one pixel per cycle while out_stall is low, set by the single
// write port of the line store and the per-pixel update of the row carry.
// When out_stall is high the result holds, and up to five further pixels are
// taken into the queue and the stage after it before in_stall rises.
// Reset clears the scan position and then runs a clearing pass over the
// line store's 1024 columns, one column per cycle, with in_stall held high.
// Configuration writes (cfg_index 0: image_width, 1: threshold) are taken in
// any cycle on cfg_valid; cfg_ready is always high.
`default_nettype none

module serpentine_error_diffusion_halftone (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [sedh_pkg::PIX_BITS-1:0]        red_in,
  input  wire logic [sedh_pkg::PIX_BITS-1:0]        green_in,
  input  wire logic [sedh_pkg::PIX_BITS-1:0]        blue_in,
  input  wire logic                                 frame_start,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      red_out,
  output logic                                      green_out,
  output logic                                      blue_out,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [sedh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [sedh_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import sedh_pkg::*;

  logic [WIDTH_CFG_BITS-1:0] image_width;
  logic [THR_BITS-1:0]       threshold;
  logic                      push;
  logic                      pop;
  logic                      clearing;
  sedh_desc_t                push_desc;
  sedh_desc_t                head;
  sedh_queue_status_t        q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_CFG_BITS'(IMAGE_WIDTH_RESET);
      threshold <= THR_BITS'(THRESHOLD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data[WIDTH_CFG_BITS-1:0];
      end else if (cfg_index == CFG_THRESHOLD) begin
        threshold <= cfg_data[THR_BITS-1:0];
      end
    end
  end

  sedh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .frame_start (frame_start),
    .image_width (image_width),
    .clearing    (clearing),
    .q_status    (q_status),
    .push        (push),
    .desc        (push_desc)
  );

  sedh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  sedh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .threshold (threshold),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

endmodule

`default_nettype wire

// ----- src/sedh_front.sv -----
// Front end: accepts pixel items, tracks the serpentine scan position and
// classifies each pixel into a descriptor for the queue. Depends on sedh_pkg.
`default_nettype none

module sedh_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [sedh_pkg::PIX_BITS-1:0]        red_in,
  input  wire logic [sedh_pkg::PIX_BITS-1:0]        green_in,
  input  wire logic [sedh_pkg::PIX_BITS-1:0]        blue_in,
  input  wire logic                                 frame_start,
  input  wire logic [sedh_pkg::WIDTH_CFG_BITS-1:0]  image_width,
  input  wire logic                                 clearing,
  input  wire sedh_pkg::sedh_queue_status_t         q_status,
  output logic                                      push,
  output sedh_pkg::sedh_desc_t                      desc
);
  import sedh_pkg::*;

  logic [COL_BITS-1:0] pos;
  logic [COL_BITS-1:0] pos_next;
  logic                reverse_row;
  logic                reverse_row_next;
  logic                in_first_row;
  logic                in_first_row_next;

  logic [COL_BITS:0]   w_eff;
  logic [COL_BITS-1:0] last_col;
  logic [COL_BITS-1:0] cur_pos;
  logic [COL_BITS-1:0] eff_pos;
  logic                cur_rev;
  logic                cur_first;
  logic [COL_BITS-1:0] x;

  assign in_stall = q_status.full | clearing;
  assign push = in_valid & ~in_stall;

  always_comb begin
    if (image_width == '0) begin
      w_eff = (COL_BITS+1)'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = (COL_BITS+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_BITS+1)'(image_width);
    end
    last_col = COL_BITS'(w_eff - (COL_BITS+1)'(1));
    cur_pos = frame_start ? '0 : pos;
    cur_rev = frame_start ? 1'b0 : reverse_row;
    cur_first = frame_start ? 1'b1 : in_first_row;
    eff_pos = (cur_pos > last_col) ? last_col : cur_pos;
    x = cur_rev ? (last_col - eff_pos) : eff_pos;

    desc.red = red_in;
    desc.green = green_in;
    desc.blue = blue_in;
    desc.x = x;
    desc.behind = cur_rev ? (x + COL_BITS'(1)) : (x - COL_BITS'(1));
    desc.last = (eff_pos == last_col);
    desc.has_behind = (eff_pos != '0);
    desc.first_row = cur_first;
    desc.clear = frame_start;
  end

  always_comb begin
    pos_next = pos;
    reverse_row_next = reverse_row;
    in_first_row_next = in_first_row;
    if (push) begin
      if (desc.last) begin
        pos_next = '0;
        reverse_row_next = ~cur_rev;
        in_first_row_next = 1'b0;
      end else begin
        pos_next = eff_pos + COL_BITS'(1);
        reverse_row_next = cur_rev;
        in_first_row_next = cur_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      reverse_row <= 1'b0;
      in_first_row <= 1'b1;
    end else begin
      pos <= pos_next;
      reverse_row <= reverse_row_next;
      in_first_row <= in_first_row_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/sedh_queue.sv -----
// Short descriptor queue between the front end and the back end.
// Depends on sedh_pkg for the descriptor type and depth.
`default_nettype none

module sedh_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire sedh_pkg::sedh_desc_t          push_desc,
  input  wire logic                          pop,
  output sedh_pkg::sedh_desc_t               head,
  output sedh_pkg::sedh_queue_status_t       status
);
  import sedh_pkg::*;

  sedh_desc_t           entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic [QPTR_BITS:0]   count_next;

  assign head = entries[rd_ptr];
  assign status.full = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign status.valid = (count != '0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + (QPTR_BITS+1)'(1);
    end else if (pop && !push) begin
      count_next = count - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/sedh_back.sv -----
// Back end: line store, error arithmetic, row carry and output register.
// Holds the line store memory and its clearing pass. Depends on sedh_pkg.
`default_nettype none

module sedh_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sedh_pkg::sedh_desc_t          head,
  input  wire sedh_pkg::sedh_queue_status_t  q_status,
  output logic                               pop,
  input  wire logic [sedh_pkg::THR_BITS-1:0] threshold,
  output logic                               clearing,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               red_out,
  output logic                               green_out,
  output logic                               blue_out
);
  import sedh_pkg::*;

  err_row_t            line_mem [MAX_WIDTH];
  err_row_t            rd_data;
  logic [COL_BITS-1:0] clr_cnt;

  sedh_desc_t          s1;
  logic                s1_valid;
  logic                s1_sel_turn;
  logic                adv;

  logic                defer_valid;
  logic [COL_BITS-1:0] defer_addr;
  err_row_t            defer_data;

  err_row_t            carry;
  err_row_t            pend0;
  err_row_t            pend1;

  logic [PIX_BITS-1:0]        pix      [CHANNELS];
  logic signed [ERR_BITS-1:0] line_v   [CHANNELS];
  logic signed [ERR_BITS-1:0] carry_v  [CHANNELS];
  logic signed [ERR_BITS-1:0] p0_v     [CHANNELS];
  logic signed [ERR_BITS-1:0] p1_v     [CHANNELS];
  logic signed [ERR_BITS-1:0] ink_v    [CHANNELS];
  logic signed [SUM_BITS-1:0] sum_v    [CHANNELS];
  logic signed [ERR_BITS-1:0] sat_v    [CHANNELS];
  logic signed [ERR_BITS-1:0] err_v    [CHANNELS];
  logic signed [ERR_BITS+3:0] err_w    [CHANNELS];
  logic [CHANNELS-1:0]        ink_on;
  logic signed [ERR_BITS-1:0] thr_fix;
  err_row_t                   carry_new;
  err_row_t                   pend0_new;
  err_row_t                   pend1_new;
  err_row_t                   below_new;

  function automatic logic signed [ERR_BITS-1:0] div16(input logic signed [ERR_BITS+3:0] val);
    logic signed [ERR_BITS+3:0] adj;
    adj = val;
    if (val[ERR_BITS+3]) begin
      adj = val + (ERR_BITS+4)'(5'sd15);
    end
    return ERR_BITS'(adj >>> 4);
  endfunction

  assign adv = s1_valid & (~out_valid | ~out_stall);
  assign pop = q_status.valid & (~s1_valid | adv) & ~clearing;

  always_comb begin
    pix[0] = s1.red;
    pix[1] = s1.green;
    pix[2] = s1.blue;
    thr_fix = $signed(ERR_BITS'({threshold, {FRAC_BITS{1'b0}}}));
    for (int c = 0; c < CHANNELS; c++) begin
      if (s1.first_row) begin
        line_v[c] = '0;
      end else if (s1_sel_turn) begin
        line_v[c] = $signed(defer_data[c]);
      end else begin
        line_v[c] = $signed(rd_data[c]);
      end
      carry_v[c] = s1.clear ? '0 : $signed(carry[c]);
      p0_v[c] = s1.clear ? '0 : $signed(pend0[c]);
      p1_v[c] = s1.clear ? '0 : $signed(pend1[c]);
      ink_v[c] = $signed(ERR_BITS'({~pix[c], {FRAC_BITS{1'b0}}}));
      sum_v[c] = SUM_BITS'(ink_v[c]) + SUM_BITS'(line_v[c]) + SUM_BITS'(carry_v[c]);
      if (sum_v[c] > VMAX) begin
        sat_v[c] = ERR_BITS'(VMAX);
      end else if (sum_v[c] < VMIN) begin
        sat_v[c] = ERR_BITS'(VMIN);
      end else begin
        sat_v[c] = ERR_BITS'(sum_v[c]);
      end
      ink_on[c] = (sat_v[c] > thr_fix);
      err_v[c] = ink_on[c] ? (sat_v[c] - FULL_INK) : sat_v[c];
      err_w[c] = (ERR_BITS+4)'(err_v[c]);
      carry_new[c] = div16((err_w[c] <<< 3) - err_w[c]);
      below_new[c] = p0_v[c] + div16((err_w[c] <<< 1) + err_w[c]);
      pend0_new[c] = p1_v[c] + div16((err_w[c] <<< 2) + err_w[c]);
      pend1_new[c] = div16(err_w[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      line_mem[clr_cnt] <= '0;
    end else if (adv && s1.has_behind) begin
      line_mem[s1.behind] <= below_new;
    end else if (adv && defer_valid) begin
      line_mem[defer_addr] <= defer_data;
    end
    if (pop) begin
      rd_data <= line_mem[head.x];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= head;
      if (adv && s1.last) begin
        s1_sel_turn <= (head.x == s1.x);
      end else begin
        s1_sel_turn <= defer_valid && (head.x == defer_addr);
      end
    end
    if (adv) begin
      red_out <= ~ink_on[0];
      green_out <= ~ink_on[1];
      blue_out <= ~ink_on[2];
      if (s1.last) begin
        defer_addr <= s1.x;
        defer_data <= pend0_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      defer_valid <= 1'b0;
      carry <= '0;
      pend0 <= '0;
      pend1 <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + COL_BITS'(1);
        if (clr_cnt == COL_BITS'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        defer_valid <= s1.last;
        if (s1.last) begin
          carry <= '0;
          pend0 <= '0;
          pend1 <= '0;
        end else begin
          carry <= carry_new;
          pend0 <= pend0_new;
          pend1 <= pend1_new;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/sedh_checker.sv -----
// Port-level checks for the halftoner top level, attached with a bind.
// Depends on sedh_pkg and on the top level's port list.
`default_nettype none

module sedh_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_stall,
  input wire logic [sedh_pkg::PIX_BITS-1:0]        red_in,
  input wire logic [sedh_pkg::PIX_BITS-1:0]        green_in,
  input wire logic [sedh_pkg::PIX_BITS-1:0]        blue_in,
  input wire logic                                 frame_start,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic                                 red_out,
  input wire logic                                 green_out,
  input wire logic                                 blue_out,
  input wire logic                                 cfg_valid,
  input wire logic                                 cfg_ready,
  input wire logic [sedh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input wire logic [sedh_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // A stalled result keeps its colors until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out))
    else $error("stalled output item changed");

  // A stalled input item stays offered with the same pixel.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(red_in) && $stable(green_in)
      && $stable(blue_in) && $stable(frame_start))
    else $error("stalled input item changed");

  // Configuration writes are always taken and carry known values.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
    else $error("configuration write not taken or unknown");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // The line store clearing pass blocks input right after reset.
  a_reset_clear: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during line store clearing");

endmodule

bind serpentine_error_diffusion_halftone sedh_checker u_sedh_checker (.*);

`default_nettype wire
